// ===== rtl/vfcm_pkg.sv =====
package vfcm_pkg;

    localparam int CfgW   = 14;              // size register width
    localparam int ModeW  = 3;
    localparam int IdxW   = 3;
    localparam int CoordW = 16;
    localparam int VpW    = 28;              // viewport size, up to a 14x14 product
    localparam int OfsW   = VpW + 1;         // signed viewport offset
    localparam int OpW    = OfsW + 1;        // signed multiplier operand
    localparam int QW     = 44;              // dividend magnitude / quotient
    localparam int PW     = QW + 1;          // signed product kept
    localparam int NStep  = QW;              // one divider stage per quotient bit

    localparam logic [IdxW-1:0] REG_PHYS_W = 3'd0;
    localparam logic [IdxW-1:0] REG_PHYS_H = 3'd1;
    localparam logic [IdxW-1:0] REG_USER_W = 3'd2;
    localparam logic [IdxW-1:0] REG_USER_H = 3'd3;
    localparam logic [IdxW-1:0] REG_MODE   = 3'd4;

    localparam logic [ModeW-1:0] MODE_NONE    = 3'd0;
    localparam logic [ModeW-1:0] MODE_STRETCH = 3'd1;
    localparam logic [ModeW-1:0] MODE_FIT_W   = 3'd2;
    localparam logic [ModeW-1:0] MODE_FIT_H   = 3'd3;
    localparam logic [ModeW-1:0] MODE_FULL    = 3'd4;

    typedef enum logic [1:0] {
        OP_P2U    = 2'd0,
        OP_U2P    = 2'd1,
        OP_INSIDE = 2'd2,
        OP_CLAMP  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              negx;
        logic              negy;
        logic              zx;
        logic              zy;
        logic              pass;
        logic              hit;
        logic [CoordW-1:0] altx;
        logic [CoordW-1:0] alty;
    } t_side;

    typedef struct packed {
        logic [QW-1:0]  acc;   // dividend bits out the top, quotient bits in the bottom
        logic [VpW-1:0] rem;
        logic [VpW-1:0] den;
    } t_div;

    // one restoring division step
    function automatic t_div div_step(t_div d);
        logic [VpW:0] t;
        logic         ge;
        t_div         r;
        t     = {d.rem, d.acc[QW-1]};
        ge    = (t >= {1'b0, d.den});
        r.den = d.den;
        r.rem = ge ? VpW'(t - {1'b0, d.den}) : t[VpW-1:0];
        r.acc = {d.acc[QW-2:0], ge};
        return r;
    endfunction

endpackage

// ===== rtl/viewport_fit_coordinate_mapper.sv =====
// Viewport fit coordinate mapper. One point (x, y) plus an op enters per item and one
// result leaves per item; a new item is taken every cycle unless the output stalls
// or the viewport is being rebuilt. Each item passes the input, offset/compare and
// multiply stages, the 44-stage restoring divider (one stage per quotient bit) and
// the output register. Stalls on the output freeze the whole pipe. After any
// configuration write the viewport is rebuilt by a serial divider, while
// s_axis_tready stays low. Ops: phys to user, user to phys, inside test, clamp.
module viewport_fit_coordinate_mapper
    import vfcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [IdxW-1:0]       i_cfg_addr,
    input  logic [CfgW-1:0]       i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [2*CoordW-1:0]   i_s_axis_tdata,   // x_in[15:0], y_in[31:16]
    input  logic [1:0]            i_s_axis_tuser,   // op[1:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [2*CoordW-1:0]   o_m_axis_tdata,   // x_out[15:0], y_out[31:16]
    output logic [1:0]            o_m_axis_tuser    // inside_res[0], div_error[1]
);

    // ---------------- configuration and viewport builder ----------------
    typedef enum logic [2:0] {
        ST_IDLE, ST_LDA, ST_DVA, ST_LDB, ST_DVB, ST_SEL, ST_OFS
    } t_state;

    t_state             r_state;
    logic [CfgW-1:0]    r_pw, r_ph, r_uw, r_uh;
    logic [ModeW-1:0]   r_mode;
    logic [VpW-1:0]     r_vw, r_vh, r_qa, r_qb;
    logic signed [OfsW-1:0] r_ofx, r_ofy;
    logic [VpW-1:0]     r_dacc;
    logic [CfgW-1:0]    r_drem, r_dden;
    logic [4:0]         r_cnt;

    logic [CfgW:0]      w_t;
    logic               w_ge;
    logic [VpW-1:0]     w_nacc;
    logic [CfgW-1:0]    w_nrem;
    logic signed [OfsW-1:0] w_dx, w_dy;

    // serial divide step for the viewport ratios
    always_comb begin
        w_t    = {r_drem, r_dacc[VpW-1]};
        w_ge   = (w_t >= {1'b0, r_dden});
        w_nrem = w_ge ? CfgW'(w_t - {1'b0, r_dden}) : w_t[CfgW-1:0];
        w_nacc = {r_dacc[VpW-2:0], w_ge};
        w_dx   = $signed({15'd0, r_pw}) - $signed({1'b0, r_vw});
        w_dy   = $signed({15'd0, r_ph}) - $signed({1'b0, r_vh});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pw    <= '0;
            r_ph    <= '0;
            r_uw    <= '0;
            r_uh    <= '0;
            r_mode  <= '0;
            r_vw    <= '0;
            r_vh    <= '0;
            r_ofx   <= '0;
            r_ofy   <= '0;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PHYS_W: r_pw   <= i_cfg_wdata;
                REG_PHYS_H: r_ph   <= i_cfg_wdata;
                REG_USER_W: r_uw   <= i_cfg_wdata;
                REG_USER_H: r_uh   <= i_cfg_wdata;
                REG_MODE:   r_mode <= i_cfg_wdata[ModeW-1:0];
                default: ;
            endcase
            r_state <= ST_LDA;
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_LDA: begin
                    r_dacc  <= r_pw * r_uh;
                    r_dden  <= r_uw;
                    r_drem  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DVA;
                end
                ST_DVA: begin
                    r_dacc <= w_nacc;
                    r_drem <= w_nrem;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(VpW - 1)) begin
                        r_qa    <= (r_dden == '0) ? '0 : w_nacc;
                        r_state <= ST_LDB;
                    end
                end
                ST_LDB: begin
                    r_dacc  <= r_ph * r_uw;
                    r_dden  <= r_uh;
                    r_drem  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DVB;
                end
                ST_DVB: begin
                    r_dacc <= w_nacc;
                    r_drem <= w_nrem;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(VpW - 1)) begin
                        r_qb    <= (r_dden == '0) ? '0 : w_nacc;
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    unique case (r_mode)
                        MODE_STRETCH: begin
                            r_vw <= VpW'(r_pw);
                            r_vh <= VpW'(r_ph);
                        end
                        MODE_FIT_W: begin
                            r_vw <= VpW'(r_pw);
                            r_vh <= r_qa;
                        end
                        MODE_FIT_H: begin
                            r_vw <= r_qb;
                            r_vh <= VpW'(r_ph);
                        end
                        MODE_FULL: begin
                            // fit to width unless that comes out too tall
                            if (r_qa > VpW'(r_ph)) begin
                                r_vw <= r_qb;
                                r_vh <= VpW'(r_ph);
                            end else begin
                                r_vw <= VpW'(r_pw);
                                r_vh <= r_qa;
                            end
                        end
                        default: begin
                            r_vw <= VpW'(r_uw);
                            r_vh <= VpW'(r_uh);
                        end
                    endcase
                    r_state <= ST_OFS;
                end
                ST_OFS: begin
                    // halve toward zero
                    r_ofx   <= (w_dx + $signed({28'd0, w_dx[OfsW-1]})) >>> 1;
                    r_ofy   <= (w_dy + $signed({28'd0, w_dy[OfsW-1]})) >>> 1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- item pipeline ----------------
    logic w_en;       // whole pipe advances
    logic r_ov;
    assign w_en            = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = w_en && (r_state == ST_IDLE);

    // S0: input register
    logic                     r_v0;
    t_op                      r_op0;
    logic signed [CoordW-1:0] r_x0, r_y0;

    // S1: offsets, compares, multiplier operands
    logic                     r_v1;
    t_side                    r_side1;
    logic signed [OpW-1:0]    r_ax, r_ay;
    logic signed [OfsW-1:0]   r_bx, r_by;
    logic [VpW-1:0]           r_denx1, r_deny1;

    // S2: products
    logic                     r_v2;
    t_side                    r_side2;
    logic signed [PW-1:0]     r_px, r_py;
    logic [VpW-1:0]           r_denx2, r_deny2;

    // divider stages
    logic                     r_dv    [NStep];
    t_side                    r_dside [NStep];
    t_div                     r_ddx   [NStep];
    t_div                     r_ddy   [NStep];

    // output register
    logic [CoordW-1:0]        r_rx, r_ry;
    logic                     r_rin, r_rerr;

    // S1 combinational
    logic signed [OpW-1:0]    w_x30, w_y30, w_ox30, w_oy30, w_hix, w_hiy, w_ddx, w_ddy;
    logic                     w_ltx, w_gtx, w_lty, w_gty;
    t_side                    n_side1;
    logic signed [OpW-1:0]    n_ax, n_ay;
    logic signed [OfsW-1:0]   n_bx, n_by;
    logic [VpW-1:0]           n_denx, n_deny;

    always_comb begin
        w_x30  = {{(OpW-CoordW){r_x0[CoordW-1]}}, r_x0};
        w_y30  = {{(OpW-CoordW){r_y0[CoordW-1]}}, r_y0};
        w_ox30 = {r_ofx[OfsW-1], r_ofx};
        w_oy30 = {r_ofy[OfsW-1], r_ofy};
        w_hix  = w_ox30 + $signed({2'b00, r_vw});
        w_hiy  = w_oy30 + $signed({2'b00, r_vh});
        w_ddx  = w_x30 - w_ox30;
        w_ddy  = w_y30 - w_oy30;
        w_ltx  = w_x30 < w_ox30;
        w_gtx  = w_x30 > w_hix;
        w_lty  = w_y30 < w_oy30;
        w_gty  = w_y30 > w_hiy;

        n_side1        = '0;
        n_side1.op     = r_op0;
        n_side1.hit    = (r_op0 == OP_INSIDE) && !w_ltx && !w_gtx && !w_lty && !w_gty;
        n_side1.zx     = (r_op0 == OP_P2U) && (r_vw == '0);
        n_side1.zy     = (r_op0 == OP_P2U) && (r_vh == '0);
        n_side1.pass   = (r_op0 == OP_U2P) && ((r_uw == '0) || (r_uh == '0));
        if (r_op0 == OP_CLAMP) begin
            n_side1.altx = w_ltx ? w_ox30[CoordW-1:0] :
                           w_gtx ? w_hix[CoordW-1:0] : r_x0;
            n_side1.alty = w_lty ? w_oy30[CoordW-1:0] :
                           w_gty ? w_hiy[CoordW-1:0] : r_y0;
        end else begin
            n_side1.altx = r_x0;
            n_side1.alty = r_y0;
        end

        if (r_op0 == OP_P2U) begin
            n_ax   = w_ddx;
            n_ay   = w_ddy;
            n_bx   = $signed({15'd0, r_uw});
            n_by   = $signed({15'd0, r_uh});
            n_denx = r_vw;
            n_deny = r_vh;
        end else begin
            n_ax   = w_x30;
            n_ay   = w_y30;
            n_bx   = $signed({1'b0, r_vw});
            n_by   = $signed({1'b0, r_vh});
            n_denx = VpW'(r_uw);
            n_deny = VpW'(r_uh);
        end
        // zero divisors are overridden at the end; keep the divider sane
        if (n_denx == '0) n_denx = VpW'(1);
        if (n_deny == '0) n_deny = VpW'(1);
    end

    // S2 combinational: products
    logic signed [OpW+OfsW-1:0] w_fpx, w_fpy;
    assign w_fpx = r_ax * r_bx;
    assign w_fpy = r_ay * r_by;

    // divider load from S2: magnitudes and signs
    t_div  w_lx, w_ly;
    t_side w_lside;
    always_comb begin
        w_lx.acc      = r_px[PW-1] ? QW'(-r_px) : r_px[QW-1:0];
        w_lx.rem      = '0;
        w_lx.den      = r_denx2;
        w_ly.acc      = r_py[PW-1] ? QW'(-r_py) : r_py[QW-1:0];
        w_ly.rem      = '0;
        w_ly.den      = r_deny2;
        w_lside       = r_side2;
        w_lside.negx  = r_px[PW-1];
        w_lside.negy  = r_py[PW-1];
    end

    t_div n_ddx [NStep];
    t_div n_ddy [NStep];
    always_comb begin
        n_ddx[0] = div_step(w_lx);
        n_ddy[0] = div_step(w_ly);
        for (int i = 1; i < NStep; i++) begin
            n_ddx[i] = div_step(r_ddx[i-1]);
            n_ddy[i] = div_step(r_ddy[i-1]);
        end
    end

    // final selection
    t_side             w_fs;
    logic [CoordW-1:0] w_qx, w_qy, n_rx, n_ry;
    logic              n_rin, n_rerr;
    always_comb begin
        w_fs   = r_dside[NStep-1];
        w_qx   = r_ddx[NStep-1].acc[CoordW-1:0];
        w_qy   = r_ddy[NStep-1].acc[CoordW-1:0];
        if (w_fs.negx) w_qx = -w_qx;
        if (w_fs.negy) w_qy = -w_qy;
        n_rx   = '0;
        n_ry   = '0;
        n_rin  = 1'b0;
        n_rerr = 1'b0;
        case (w_fs.op)
            OP_P2U: begin
                n_rx   = w_fs.zx ? '0 : w_qx;
                n_ry   = w_fs.zy ? '0 : w_qy;
                n_rerr = w_fs.zx || w_fs.zy;
            end
            OP_U2P: begin
                n_rx = w_fs.pass ? w_fs.altx : w_qx + r_ofx[CoordW-1:0];
                n_ry = w_fs.pass ? w_fs.alty : w_qy + r_ofy[CoordW-1:0];
            end
            OP_INSIDE: n_rin = w_fs.hit;
            default: begin
                n_rx = w_fs.altx;
                n_ry = w_fs.alty;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i < NStep; i++) r_dv[i] <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_axis_tvalid && o_s_axis_tready;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_dv[0] <= r_v2;
            for (int i = 1; i < NStep; i++) r_dv[i] <= r_dv[i-1];
            r_ov <= r_dv[NStep-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op0   <= t_op'(i_s_axis_tuser);
            r_x0    <= i_s_axis_tdata[CoordW-1:0];
            r_y0    <= i_s_axis_tdata[2*CoordW-1:CoordW];
            r_side1 <= n_side1;
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_denx1 <= n_denx;
            r_deny1 <= n_deny;
            r_side2 <= r_side1;
            r_px    <= w_fpx[PW-1:0];
            r_py    <= w_fpy[PW-1:0];
            r_denx2 <= r_denx1;
            r_deny2 <= r_deny1;
            r_dside[0] <= w_lside;
            for (int i = 1; i < NStep; i++) r_dside[i] <= r_dside[i-1];
            for (int i = 0; i < NStep; i++) begin
                r_ddx[i] <= n_ddx[i];
                r_ddy[i] <= n_ddy[i];
            end
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_rin  <= n_rin;
            r_rerr <= n_rerr;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_ry, r_rx};
    assign o_m_axis_tuser  = {r_rerr, r_rin};

`ifndef SYNTHESIS
    // no item enters while the viewport is being rebuilt
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_axis_tready)
        else $error("item accepted during viewport rebuild");

    // a configuration write always starts a rebuild
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == ST_LDA))
        else $error("config write did not start rebuild");

    // divide error only with a zero viewport size
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rerr) |-> ((r_vw == '0) || (r_vh == '0)))
        else $error("div_error with nonzero viewport");

    // inside flag and divide error never together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_rin && r_rerr))
        else $error("inside and div_error both set");
`endif

endmodule
